// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check an implication at every rising edge, off while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/mexp_pkg.sv =====
// ---------------------------------------------------------------------------
// Modular exponentiation package
// Shared constants, register indexes and unit status type.
// ---------------------------------------------------------------------------
package mexp_pkg;

  localparam int DEFAULT_WIDTH = 32;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS  = 2'd1;

  localparam logic [63:0] EXPONENT_RESET = 64'd65537;
  localparam logic [63:0] MODULUS_RESET  = 64'd3233;

  typedef struct packed {
    logic busy;
    logic done;
  } mexp_stat_t;

endpackage

// ===== hdl/mexp_modmul.sv =====
// ---------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes x * y mod m one multiplier bit per cycle, most significant first,
// with the reduction folded into every step. Needs x < m.
// ---------------------------------------------------------------------------
module mexp_modmul import mexp_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  logic [WIDTH-1:0] m,
  output logic [WIDTH-1:0] product,
  output mexp_stat_t       stat
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] x_reg;
  logic [WIDTH-1:0] y_reg;
  logic [WIDTH-1:0] m_reg;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic             done;

  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] m1;
  logic [WIDTH+1:0] m2;
  logic [WIDTH+1:0] red;
  logic [WIDTH-1:0] acc_next;

  // 2*acc + bit*x stays below 3m: subtract 0, m or 2m
  always_comb begin
    sum = {1'b0, acc, 1'b0} + {2'b00, (y_reg[WIDTH-1] ? x_reg : '0)};
    m1  = {2'b00, m_reg};
    m2  = {1'b0, m_reg, 1'b0};
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
    acc_next = red[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= '0;
      x_reg <= x;
      y_reg <= y;
      m_reg <= m;
      cnt   <= CW'(WIDTH - 1);
    end else if (busy) begin
      acc   <= acc_next;
      y_reg <= {y_reg[WIDTH-2:0], 1'b0};
      cnt   <= cnt - 1'b1;
    end
  end

  assign product   = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== hdl/modular_exponentiation_core.sv =====
// ---------------------------------------------------------------------------
// Modular exponentiation core
// Raises each base word to the configured exponent modulo the configured
// modulus by right-to-left square-and-multiply on one shared multiplier.
// ---------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------
//  cfg     | cfg_write             | cfg_index, cfg_data
//  in      | in_valid / in_ready   | base
//  out     | out_valid / out_ready | power
//
//  Each product holds the bit-serial multiplier, then ST_BIT picks the next
//  step. A word costs one reduction, one square per exponent bit below the
//  top set bit and one multiply per set bit: at most 2*WIDTH products. A zero
//  modulus skips the multiplier and goes straight to ST_FINISH. in_ready is
//  high only in idle; a finished word waits in the output register while the
//  next is taken. Sync reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module modular_exponentiation_core import mexp_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [WIDTH-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [WIDTH-1:0]          base,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [WIDTH-1:0]          power
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_BIT,
    ST_MUL,
    ST_SQR,
    ST_FINISH
  } state_t;

  state_t           state;
  logic [WIDTH-1:0] exponent;
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] e_sh;
  logic [WIDTH-1:0] res;
  logic [WIDTH-1:0] sq;
  logic             mul_start;
  logic [WIDTH-1:0] mul_x;
  logic [WIDTH-1:0] mul_y;
  logic [WIDTH-1:0] product;
  mexp_stat_t       mul_stat;
  logic [WIDTH-1:0] one_m;
  logic             mod_set;
  logic             mul_wait;
  logic             ops_below;

  assign one_m     = (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
  assign in_ready  = (state == ST_IDLE);
  assign mod_set   = (modulus != '0);
  assign mul_wait  = state inside {ST_REDUCE, ST_MUL, ST_SQR};
  assign ops_below = (res < modulus) && (sq < modulus);

  mexp_modmul #(.WIDTH(WIDTH)) u_modmul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .x       (mul_x),
    .y       (mul_y),
    .m       (modulus),
    .product (product),
    .stat    (mul_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= EXPONENT_RESET[WIDTH-1:0];
      modulus  <= MODULUS_RESET[WIDTH-1:0];
    end else if (cfg_write) begin
      case (cfg_index)
        REG_EXPONENT: exponent <= cfg_data;
        REG_MODULUS:  modulus  <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      mul_start <= 1'b0;
    end else begin
      if (state == ST_FINISH && (!out_valid || out_ready)) begin
        power     <= res;
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          mul_start <= in_valid && mod_set;
          if (in_valid) begin
            if (modulus == '0) begin
              res   <= '0;
              state <= ST_FINISH;
            end else begin
              res   <= one_m;
              e_sh  <= exponent;
              mul_x <= one_m;
              mul_y <= base;
              state <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          mul_start <= 1'b0;
          if (mul_stat.done) begin
            sq    <= product;
            state <= ST_BIT;
          end
        end
        ST_BIT: begin
          mul_start <= (e_sh != '0);
          if (e_sh == '0) begin
            state <= ST_FINISH;
          end else if (e_sh[0]) begin
            mul_x <= res;
            mul_y <= sq;
            state <= ST_MUL;
          end else begin
            mul_x <= sq;
            mul_y <= sq;
            state <= ST_SQR;
          end
        end
        ST_MUL: begin
          mul_start <= 1'b0;
          if (mul_stat.done) begin
            res     <= product;
            e_sh[0] <= 1'b0;
            state   <= ST_BIT;
          end
        end
        ST_SQR: begin
          mul_start <= 1'b0;
          if (mul_stat.done) begin
            sq    <= product;
            e_sh  <= {1'b0, e_sh[WIDTH-1:1]};
            state <= ST_BIT;
          end
        end
        ST_FINISH: begin
          mul_start <= 1'b0;
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          mul_start <= 1'b0;
          state     <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPLY(a_power_reduced, clk, rst, out_valid && mod_set, power < modulus, "unreduced power")
  `ASSERT_IMPLY(a_mul_busy_in_wait, clk, rst, mul_stat.busy, mul_wait, "busy outside wait")
  `ASSERT_IMPLY(a_out_from_finish, clk, rst, $rose(out_valid), $past(state == ST_FINISH), "bad load")
  `ASSERT_IMPLY(a_res_reduced, clk, rst, state == ST_BIT && mod_set, ops_below, "unreduced")

endmodule
